// ===== rtl/oets_pkg.sv =====
// ----------------------------------------------------------------------------
// oets_pkg: shared types for the odd-even transposition sorter
// Holds the controller state type, the cell operation codes and the control
// bundle that the controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package oets_pkg;

    // Width of the key field on the stream ports.
    localparam int unsigned DATA_WIDTH = 32;

    // Controller states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    // Operation that every cell performs in the current cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SORT_ODD,
        CELL_SORT_EVEN,
        CELL_EMIT
    } cell_op_t;

    // Control broadcast from the controller to the cells.
    typedef struct packed {
        cell_op_t op;
        logic     descending;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/oets_cell.sv =====
// ----------------------------------------------------------------------------
// oets_cell: one storage cell of the sorting chain
// Holds one key and its valid bit. It shifts keys up while loading, shifts
// them down while emitting, and takes part in at most one compare-exchange
// pair per sorting phase depending on its position parity.
// ----------------------------------------------------------------------------
`default_nettype none

module oets_cell #(
    parameter int unsigned KEY_WIDTH = 32,
    parameter int unsigned INDEX     = 0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire oets_pkg::cell_ctrl_t  ctrl,
    input  wire logic [KEY_WIDTH-1:0]  lo_key,
    input  wire logic                  lo_valid,
    input  wire logic [KEY_WIDTH-1:0]  hi_key,
    input  wire logic                  hi_valid,
    output logic      [KEY_WIDTH-1:0]  key,
    output logic                       valid,
    output logic                       swap
);

    localparam bit IDX_ODD = (INDEX % 2) == 1;

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 valid_reg, valid_next;
    logic                 is_low;
    logic                 is_high;
    logic                 high_out_of_order;
    logic                 low_out_of_order;

    // Role of this cell in the current phase.
    always_comb begin
        is_low  = 1'b0;
        is_high = 1'b0;
        if (ctrl.op == oets_pkg::CELL_SORT_ODD) begin
            is_low  = !IDX_ODD;
            is_high = IDX_ODD;
        end else if (ctrl.op == oets_pkg::CELL_SORT_EVEN) begin
            is_low  = IDX_ODD;
            is_high = !IDX_ODD && (INDEX != 0);
        end
    end

    // Compare with the partner cell; the lower position holds the first key.
    always_comb begin
        high_out_of_order = valid_reg &&
            (ctrl.descending ? (lo_key < key_reg) : (lo_key > key_reg));
        low_out_of_order  = hi_valid &&
            (ctrl.descending ? (key_reg < hi_key) : (key_reg > hi_key));
    end

    // Next key and valid bit.
    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            oets_pkg::CELL_LOAD: begin
                key_next   = lo_key;
                valid_next = lo_valid;
            end
            oets_pkg::CELL_EMIT: begin
                key_next   = hi_key;
                valid_next = hi_valid;
            end
            oets_pkg::CELL_SORT_ODD,
            oets_pkg::CELL_SORT_EVEN: begin
                if (is_high && high_out_of_order) begin
                    key_next = lo_key;
                end else if (is_low && low_out_of_order) begin
                    key_next = hi_key;
                end
            end
            default: begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Key storage needs no reset; the valid bit does.
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign swap  = is_low && low_out_of_order;

endmodule

`default_nettype wire

// ===== rtl/odd_even_transposition_sorter.sv =====
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter: burst sorter built from a chain of cells
// Collects a burst of unsigned keys, sorts it by odd-even transposition and
// streams the keys back out in ascending or descending order.
// ----------------------------------------------------------------------------
// The block takes a burst of up to MAX_KEYS keys, one word per cycle on the
// s_ side; the word with s_tlast set closes the burst, and keys beyond
// MAX_KEYS are dropped (a dropped word with s_tlast still closes the burst).
// Each key sits in its own cell of a chain. After the burst closes, one
// compare-exchange phase runs per cycle across all cells at once, odd and even
// phases alternating, until two phases in a row swap nothing. The sorted keys
// then leave on the m_ side one word per cycle while m_tready is high, with
// m_tlast on the final key. No new key is accepted until the last sorted key
// has been taken. cfg_data bit selects descending order; it is sampled when a
// burst closes. The user must write it only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_transposition_sorter #(
    parameter int unsigned MAX_KEYS  = 16,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data,   // sort_descending
    // Input key stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [oets_pkg::DATA_WIDTH-1:0]   s_tdata,    // key_value
    input  wire logic                              s_tlast,    // is_last_key
    // Sorted key stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [oets_pkg::DATA_WIDTH-1:0]   m_tdata,    // sorted_key
    output logic                                   m_tlast     // is_last_sorted
);

    oets_pkg::state_t     state_reg, state_next;
    logic                 phase_odd_reg, phase_odd_next;
    logic [1:0]           quiet_reg, quiet_next;
    logic                 cfg_desc_reg;
    logic                 desc_reg, desc_next;
    oets_pkg::cell_ctrl_t ctrl;

    logic [KEY_WIDTH-1:0] cell_key   [MAX_KEYS];
    logic [MAX_KEYS-1:0]  cell_valid;
    logic [MAX_KEYS-1:0]  cell_swap;
    logic [KEY_WIDTH-1:0] in_key;
    logic                 full;
    logic                 any_swap;
    logic                 in_fire;
    logic                 out_fire;

    assign in_key   = KEY_WIDTH'(s_tdata);
    assign full     = cell_valid[MAX_KEYS-1];
    assign any_swap = |cell_swap;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_desc_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            cfg_desc_reg <= cfg_data;
        end
    end

    // Next state, phase parity and quiet phase count.
    always_comb begin
        state_next     = state_reg;
        phase_odd_next = phase_odd_reg;
        quiet_next     = quiet_reg;
        desc_next      = desc_reg;
        case (state_reg)
            oets_pkg::ST_LOAD: begin
                if (in_fire && s_tlast) begin
                    state_next     = oets_pkg::ST_SORT;
                    phase_odd_next = 1'b1;
                    quiet_next     = 2'd0;
                    desc_next      = cfg_desc_reg;
                end
            end
            oets_pkg::ST_SORT: begin
                phase_odd_next = !phase_odd_reg;
                quiet_next     = any_swap ? 2'd0 : quiet_reg + 2'd1;
                if (!any_swap && quiet_reg == 2'd1) begin
                    state_next = oets_pkg::ST_EMIT;
                end
            end
            oets_pkg::ST_EMIT: begin
                if (out_fire && m_tlast) begin
                    state_next     = oets_pkg::ST_LOAD;
                    phase_odd_next = 1'b1;
                    quiet_next     = 2'd0;
                end
            end
            default: begin
                state_next = oets_pkg::ST_LOAD;
            end
        endcase
    end

    // Handshakes and the operation broadcast to the cells.
    always_comb begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        ctrl.op         = oets_pkg::CELL_HOLD;
        ctrl.descending = desc_reg;
        case (state_reg)
            oets_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (in_fire && !full) begin
                    ctrl.op = oets_pkg::CELL_LOAD;
                end
            end
            oets_pkg::ST_SORT: begin
                ctrl.op = phase_odd_reg ? oets_pkg::CELL_SORT_ODD
                                        : oets_pkg::CELL_SORT_EVEN;
            end
            oets_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                if (out_fire) begin
                    ctrl.op = oets_pkg::CELL_EMIT;
                end
            end
            default: begin
                ctrl.op = oets_pkg::CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        if (!aresetn) begin
            state_reg     <= oets_pkg::ST_LOAD;
            phase_odd_reg <= 1'b1;
            quiet_reg     <= 2'd0;
        end else begin
            state_reg     <= state_next;
            phase_odd_reg <= phase_odd_next;
            quiet_reg     <= quiet_next;
        end
    end

    // The chain of cells; keys enter at cell 0 and leave from cell 0.
    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
        logic [KEY_WIDTH-1:0] lo_key;
        logic                 lo_valid;
        logic [KEY_WIDTH-1:0] hi_key;
        logic                 hi_valid;

        if (i == 0) begin : g_first
            assign lo_key   = in_key;
            assign lo_valid = 1'b1;
        end else begin : g_inner_lo
            assign lo_key   = cell_key[i-1];
            assign lo_valid = cell_valid[i-1];
        end

        if (i == MAX_KEYS - 1) begin : g_last
            assign hi_key   = '0;
            assign hi_valid = 1'b0;
        end else begin : g_inner_hi
            assign hi_key   = cell_key[i+1];
            assign hi_valid = cell_valid[i+1];
        end

        oets_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .INDEX     (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .lo_key   (lo_key),
            .lo_valid (lo_valid),
            .hi_key   (hi_key),
            .hi_valid (hi_valid),
            .key      (cell_key[i]),
            .valid    (cell_valid[i]),
            .swap     (cell_swap[i])
        );
    end

    // Output comes straight from the head cell of the chain.
    assign m_tdata = oets_pkg::DATA_WIDTH'(cell_key[0]);
    assign m_tlast = !cell_valid[1];

endmodule

`default_nettype wire
